// ----- rtl/mjpd_pkg.sv -----
`timescale 1ns / 1ps
package mjpd_pkg;

    localparam int JOINTS   = 16;
    localparam int JOINT_AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    localparam int POS_W  = 16;
    localparam int ERR_W  = 17;
    localparam int DIFF_W = 18;
    localparam int WORD_W = 3 * POS_W + ERR_W;

    // Serial multiplier and divider widths.
    localparam int MA_W   = 34;
    localparam int MB_W   = 20;
    localparam int PROD_W = 56;
    localparam int DVD_W  = PROD_W - 8;
    localparam int DVS_W  = 16;
    localparam int QUO_W  = DVD_W + 1;
    localparam int DCNT_W = $clog2(DVD_W);

    localparam int CFG_AW = 2;
    localparam int CFG_DW = 16;
    localparam int TOL_W  = 15;

    localparam logic [CFG_AW-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [CFG_AW-1:0] REG_HOME_TOL   = 2'd2;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_CONTROL = 2'd1;
    localparam logic [1:0] CMD_LOAD    = 2'd2;

    localparam logic [DVS_W-1:0]        DEFAULT_PERIOD = 16'd10000;
    localparam logic [MB_W-1:0]         DERIV_SCALE    = 20'd1000000;
    localparam logic signed [QUO_W-1:0] HOMING_LIMIT   = 49'sd1229;
    localparam logic [TOL_W-1:0]        HOME_TOL_RESET = 15'd41;

    typedef enum logic [1:0] {
        MODE_HOMING   = 2'd0,
        MODE_HOLDING  = 2'd1,
        MODE_EXTERNAL = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_ERR,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_DIV,
        S_FIN
    } t_state;

endpackage

// ----- rtl/mjpd_in_if.sv -----
`timescale 1ns / 1ps
interface mjpd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [3:0]         joint;
    logic signed [15:0] measured_position;
    logic signed [15:0] measured_velocity;
    logic signed [15:0] effort;
    logic [15:0]        period_us;
    logic               last_joint;

    modport source (
        output valid, cmd, joint, measured_position, measured_velocity, effort,
               period_us, last_joint,
        input  ready
    );
    modport sink (
        input  valid, cmd, joint, measured_position, measured_velocity, effort,
               period_us, last_joint,
        output ready
    );
endinterface

// ----- rtl/mjpd_out_if.sv -----
`timescale 1ns / 1ps
interface mjpd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] torque;
    logic signed [15:0] reported_position;
    logic signed [15:0] reported_velocity;
    logic [1:0]         mode;

    modport source (
        output valid, torque, reported_position, reported_velocity, mode,
        input  ready
    );
    modport sink (
        input  valid, torque, reported_position, reported_velocity, mode,
        output ready
    );
endinterface

// ----- rtl/mjpd_ram.sv -----
`timescale 1ns / 1ps
module mjpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mjpd_mul.sv -----
`timescale 1ns / 1ps
module mjpd_mul (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mjpd_pkg::MA_W-1:0]     i_mcand,
    input  logic [mjpd_pkg::MB_W-1:0]            i_mplier,
    output logic                                 o_done,
    output logic signed [mjpd_pkg::PROD_W-1:0]   o_prod
);
    import mjpd_pkg::*;

    logic                     r_busy, n_busy;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic signed [PROD_W-1:0] r_mcand, n_mcand;
    logic [MB_W-1:0]          r_mplier, n_mplier;

    // Shift-and-add, one multiplier bit per cycle; stops once no set bits remain.
    always_comb begin
        n_busy   = r_busy;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_start) begin
            n_busy   = 1'b1;
            n_acc    = '0;
            n_mcand  = PROD_W'(i_mcand);
            n_mplier = i_mplier;
        end else if (r_busy) begin
            if (r_mplier == '0) begin
                n_busy = 1'b0;
            end else begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand <<< 1;
                n_mplier = r_mplier >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_done = r_busy && (r_mplier == '0);
    assign o_prod = r_acc;
endmodule

// ----- rtl/mjpd_div.sv -----
`timescale 1ns / 1ps
module mjpd_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mjpd_pkg::DVD_W-1:0]    i_dividend,
    input  logic [mjpd_pkg::DVS_W-1:0]           i_divisor,
    output logic                                 o_done,
    output logic signed [mjpd_pkg::QUO_W-1:0]    o_quotient
);
    import mjpd_pkg::*;

    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic                    r_neg, n_neg;
    logic [DVD_W-1:0]        r_q, n_q;
    logic [DVS_W-1:0]        r_rem, n_rem;
    logic [DVS_W-1:0]        r_dvs, n_dvs;
    logic [DCNT_W-1:0]       r_cnt, n_cnt;
    logic [DVS_W:0]          w_trial;
    logic signed [QUO_W-1:0] w_mag;

    // Restoring division of the magnitude, one quotient bit per cycle.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_neg   = r_neg;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        w_trial = {r_rem, r_q[DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_neg  = i_dividend[DVD_W-1];
            n_q    = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_cnt  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dvs}) begin
                n_rem = DVS_W'(w_trial - {1'b0, r_dvs});
                n_q   = {r_q[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = DVS_W'(w_trial);
                n_q   = {r_q[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DCNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_neg <= n_neg;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    // A negative quotient with a remainder rounds one further down.
    assign w_mag      = $signed({1'b0, r_q});
    assign o_quotient = r_neg ? (-w_mag - $signed(QUO_W'(r_rem != '0))) : w_mag;
    assign o_done     = r_done;
endmodule

// ----- rtl/multi_joint_pd_homing_controller.sv -----
`timescale 1ns / 1ps
// Channel   Port     Direction  Payload
// input     i_in     sink       cmd, joint, measured_position, measured_velocity,
//                               effort, period_us, last_joint
// output    o_out    source     torque, reported_position, reported_velocity, mode
// config    i_cfg_*  write      i_cfg_idx selects the register, i_cfg_data
//
// Samples, home loads and external-control ticks go from S_READ through S_ERR to S_FIN,
// then back to idle.
// A PD tick runs four serial multiplies (one multiplier bit per step up to its highest
// set bit) and the 48-step serial divider.
// Reset is synchronous and clears mode, flags, gains and the per-joint valid bits.
// A new word is accepted only in idle; a finished result waits in the output register.
module multi_joint_pd_homing_controller (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mjpd_pkg::CFG_AW-1:0]    i_cfg_idx,
    input  logic [mjpd_pkg::CFG_DW-1:0]    i_cfg_data,
    mjpd_in_if.sink                        i_in,
    mjpd_out_if.source                     o_out
);
    import mjpd_pkg::*;

    t_state r_state, n_state;
    t_mode  r_mode;
    logic   r_eff_nz, r_unhomed;

    logic [15:0]      r_kp, r_kd;
    logic [TOL_W-1:0] r_tol;

    logic [1:0]          r_cmd;
    logic [JOINT_AW-1:0] r_addr;
    logic                r_inrange;
    logic signed [15:0]  r_mpos, r_mvel, r_eff;
    logic [DVS_W-1:0]    r_per;
    logic                r_last;

    logic signed [POS_W-1:0]  r_home, r_held, r_cur;
    logic signed [ERR_W-1:0]  r_prev, r_err;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [PROD_W-1:0] r_num;
    logic signed [QUO_W-1:0]  r_torq;
    logic [JOINTS-1:0]        r_vld;

    logic               r_o_valid;
    logic signed [15:0] r_o_torque, r_o_rpos, r_o_rvel;
    logic [1:0]         r_o_mode;

    logic                     w_accept, w_ready, w_pd, w_free, w_commit;
    logic [WORD_W-1:0]        w_rdata, w_word;
    logic signed [ERR_W-1:0]  w_err;
    logic [ERR_W-1:0]         w_err_mag;
    logic signed [DIFF_W-1:0] w_diff;
    logic                     w_mul_start, w_mul_done, w_div_start, w_div_done;
    logic signed [MA_W-1:0]   w_mul_a;
    logic [MB_W-1:0]          w_mul_b;
    logic signed [PROD_W-1:0] w_prod, w_sum;
    logic signed [QUO_W-1:0]  w_quot;

    logic signed [POS_W-1:0] w_n_home, w_n_held, w_n_cur;
    logic signed [ERR_W-1:0] w_n_prev;
    logic signed [15:0]      w_torque, w_rpos, w_rvel;
    t_mode                   w_n_mode;
    logic                    w_n_eff_nz, w_n_unhomed;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_free   = !r_o_valid || o_out.ready;
    assign w_commit = (r_state == S_FIN) && w_free;
    assign w_pd     = (r_cmd == CMD_CONTROL) && r_inrange && (r_mode != MODE_EXTERNAL);

    // Error of this joint toward its target, taken from the words read in S_READ.
    always_comb begin
        if (r_mode == MODE_HOMING) begin
            w_err = ERR_W'(r_home) - ERR_W'(r_held);
        end else begin
            w_err = ERR_W'(r_held) - ERR_W'(r_cur);
        end
        w_diff    = DIFF_W'(w_err) - DIFF_W'(r_prev);
        w_err_mag = r_err[ERR_W-1] ? ERR_W'(-r_err) : ERR_W'(r_err);
        w_sum     = r_num + w_prod;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_READ;
            S_READ: n_state = S_ERR;
            S_ERR:  n_state = w_pd ? S_M1 : S_FIN;
            S_M1:   if (w_mul_done) n_state = S_M2;
            S_M2:   if (w_mul_done) n_state = S_M3;
            S_M3:   if (w_mul_done) n_state = S_M4;
            S_M4:   if (w_mul_done) n_state = S_DIV;
            S_DIV:  if (w_div_done) n_state = S_FIN;
            S_FIN:  if (w_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // The numerator is prop*err*period + deriv*diff*1e6, built by one shared multiplier.
    always_comb begin
        w_ready     = 1'b0;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: w_ready = 1'b1;
            S_ERR: begin
                w_mul_start = w_pd;
                w_mul_a     = MA_W'(w_err);
                w_mul_b     = MB_W'(r_kp);
            end
            S_M1: begin
                w_mul_start = w_mul_done;
                w_mul_a     = MA_W'(w_prod);
                w_mul_b     = MB_W'(r_per);
            end
            S_M2: begin
                w_mul_start = w_mul_done;
                w_mul_a     = MA_W'(r_diff);
                w_mul_b     = MB_W'(r_kd);
            end
            S_M3: begin
                w_mul_start = w_mul_done;
                w_mul_a     = MA_W'(w_prod);
                w_mul_b     = DERIV_SCALE;
            end
            S_M4: w_div_start = w_mul_done;
            default: ;
        endcase
    end

    mjpd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_mcand  (w_mul_a),
        .i_mplier (w_mul_b),
        .o_done   (w_mul_done),
        .o_prod   (w_prod)
    );

    // Dividing by 256 first and then by the period gives the same floor.
    mjpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (DVD_W'(w_sum >>> 8)),
        .i_divisor  (r_per),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    mjpd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (JOINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit && r_inrange),
        .i_waddr (r_addr),
        .i_wdata ({w_n_home, w_n_held, w_n_cur, w_n_prev}),
        .i_raddr (JOINT_AW'(i_in.joint)),
        .o_rdata (w_rdata)
    );

    assign w_word = r_vld[r_addr] ? w_rdata : '0;

    // Result and state update for the word being finished.
    always_comb begin
        w_n_home    = r_home;
        w_n_held    = r_held;
        w_n_cur     = r_cur;
        w_n_prev    = r_prev;
        w_torque    = '0;
        w_rpos      = '0;
        w_rvel      = '0;
        w_n_mode    = r_mode;
        w_n_eff_nz  = r_eff_nz;
        w_n_unhomed = r_unhomed;
        if (r_inrange) begin
            case (r_cmd)
                CMD_SAMPLE: begin
                    if (r_mode == MODE_HOMING) begin
                        w_n_held = r_mpos;
                        w_n_cur  = r_home;
                        w_rpos   = r_home;
                    end else begin
                        w_n_cur = r_mpos;
                        w_rpos  = r_mpos;
                        w_rvel  = r_mvel;
                        if (r_mode == MODE_EXTERNAL) begin
                            w_n_held = r_mpos;
                        end
                    end
                end
                CMD_CONTROL: begin
                    if (r_eff != '0) begin
                        w_n_eff_nz = 1'b1;
                    end
                    unique case (r_mode)
                        MODE_HOMING: begin
                            w_n_prev = r_err;
                            if (r_torq > HOMING_LIMIT) begin
                                w_torque = 16'(HOMING_LIMIT);
                            end else if (r_torq < -HOMING_LIMIT) begin
                                w_torque = 16'(-HOMING_LIMIT);
                            end else begin
                                w_torque = 16'(r_torq);
                            end
                            if (w_err_mag > {2'b00, r_tol}) begin
                                w_n_unhomed = 1'b1;
                            end
                        end
                        MODE_EXTERNAL: w_torque = r_eff;
                        default: begin
                            w_n_prev = r_err;
                            if (r_torq > QUO_W'(32767)) begin
                                w_torque = 16'sh7FFF;
                            end else if (r_torq < -QUO_W'(32768)) begin
                                w_torque = 16'sh8000;
                            end else begin
                                w_torque = 16'(r_torq);
                            end
                        end
                    endcase
                    if (r_last) begin
                        unique case (r_mode)
                            MODE_HOMING:   if (!w_n_unhomed) w_n_mode = MODE_HOLDING;
                            MODE_EXTERNAL: if (!w_n_eff_nz) w_n_mode = MODE_HOLDING;
                            default:       if (w_n_eff_nz) w_n_mode = MODE_EXTERNAL;
                        endcase
                        w_n_eff_nz  = 1'b0;
                        w_n_unhomed = 1'b0;
                    end
                end
                CMD_LOAD: w_n_home = r_mpos;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_HOMING;
            r_eff_nz  <= 1'b0;
            r_unhomed <= 1'b0;
            r_vld     <= '0;
            r_o_valid <= 1'b0;
            r_kp      <= '0;
            r_kd      <= '0;
            r_tol     <= HOME_TOL_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PROP_GAIN:  r_kp  <= i_cfg_data;
                    REG_DERIV_GAIN: r_kd  <= i_cfg_data;
                    REG_HOME_TOL:   r_tol <= TOL_W'(i_cfg_data);
                    default: ;
                endcase
            end
            if (w_commit) begin
                r_mode    <= w_n_mode;
                r_eff_nz  <= w_n_eff_nz;
                r_unhomed <= w_n_unhomed;
                r_o_valid <= 1'b1;
                if (r_inrange) begin
                    r_vld[r_addr] <= 1'b1;
                end
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_in.cmd;
            r_addr    <= JOINT_AW'(i_in.joint);
            r_inrange <= int'(i_in.joint) < JOINTS;
            r_mpos    <= i_in.measured_position;
            r_mvel    <= i_in.measured_velocity;
            r_eff     <= i_in.effort;
            r_per     <= (i_in.period_us == '0) ? DEFAULT_PERIOD : i_in.period_us;
            r_last    <= i_in.last_joint;
        end
        if (r_state == S_READ) begin
            {r_home, r_held, r_cur, r_prev} <= w_word;
        end
        if (r_state == S_ERR) begin
            r_err  <= w_err;
            r_diff <= w_diff;
        end
        if (r_state == S_M2 && w_mul_done) begin
            r_num <= w_prod;
        end
        if (w_div_done) begin
            r_torq <= w_quot;
        end
        if (w_commit) begin
            r_o_torque <= w_torque;
            r_o_rpos   <= w_rpos;
            r_o_rvel   <= w_rvel;
            r_o_mode   <= w_n_mode;
        end
    end

    assign i_in.ready              = w_ready;
    assign o_out.valid             = r_o_valid;
    assign o_out.torque            = r_o_torque;
    assign o_out.reported_position = r_o_rpos;
    assign o_out.reported_velocity = r_o_rvel;
    assign o_out.mode              = r_o_mode;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_READ)
        else $error("accepted word did not start a RAM read");

    a_mode_at_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_mode != $past(r_mode))
            |-> $past(w_commit && r_cmd == CMD_CONTROL && r_last))
        else $error("mode changed outside a frame-end control tick");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_o_valid)) |-> $past(w_commit))
        else $error("result appeared without a commit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> r_per != '0)
        else $error("divider started with a zero period");

    a_pd_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_start |-> w_pd)
        else $error("multiplier started on a word without PD work");
endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import mjpd_pkg::*;

    typedef struct {
        logic [1:0]         cmd;
        logic [3:0]         joint;
        logic signed [15:0] pos;
        logic signed [15:0] vel;
        logic signed [15:0] eff;
        logic [15:0]        per;
        logic               last;
    } t_in_word;

    typedef struct {
        logic signed [15:0] torque;
        logic signed [15:0] rpos;
        logic signed [15:0] rvel;
        logic [1:0]         mode;
    } t_out_word;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 200;
    localparam int TORQUE_LIMIT   = 1229;

    // Command code and register index that the block has no use for.
    localparam logic [1:0]        CMD_RESERVED = 2'd3;
    localparam logic [CFG_AW-1:0] REG_UNUSED   = 2'd3;

    // Keeps its own copy of the controller state and predicts one word per input.
    class pd_scoreboard;
        int unsigned kp, kd, tol;
        t_mode       mode;
        int          home[JOINTS];
        int          held[JOINTS];
        int          cur[JOINTS];
        int          prev_err[JOINTS];
        bit          effort_seen, unhomed;
        t_out_word   pending_q[$];
        int          errors, checked, mode_changes;

        function new();
            kp = 0;
            kd = 0;
            tol = 32'(HOME_TOL_RESET);
            mode = MODE_HOMING;
            foreach (home[i]) begin
                home[i] = 0;
                held[i] = 0;
                cur[i] = 0;
                prev_err[i] = 0;
            end
            effort_seen = 0;
            unhomed = 0;
            errors = 0;
            checked = 0;
            mode_changes = 0;
        endfunction

        function void set_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
            case (idx)
                REG_PROP_GAIN:  kp = 32'(d);
                REG_DERIV_GAIN: kd = 32'(d);
                REG_HOME_TOL:   tol = 32'(d[TOL_W-1:0]);
                default: ;
            endcase
        endfunction

        // One rounding toward minus infinity over the whole PD expression.
        function longint pd_effort(int j, int e, longint p);
            longint num, den, q;
            num = longint'(kp) * e * p + longint'(kd) * (longint'(e) - prev_err[j]) * 1000000;
            den = 256 * p;
            prev_err[j] = e;
            q = num / den;
            if ((num % den) != 0 && num < 0) q--;
            return q;
        endfunction

        function void note_word(t_in_word w);
            t_out_word r;
            int        j, e;
            longint    p, t;
            t_mode     old_mode;
            j = int'(w.joint);
            p = (w.per == 0) ? longint'(DEFAULT_PERIOD) : longint'(w.per);
            r.torque = 0;
            r.rpos = 0;
            r.rvel = 0;
            old_mode = mode;
            if (w.cmd == CMD_SAMPLE) begin
                if (mode == MODE_HOMING) begin
                    held[j] = int'(w.pos);
                    cur[j] = home[j];
                end else begin
                    cur[j] = int'(w.pos);
                    r.rvel = w.vel;
                    if (mode == MODE_EXTERNAL) held[j] = int'(w.pos);
                end
                r.rpos = 16'(cur[j]);
            end else if (w.cmd == CMD_CONTROL) begin
                if (w.eff != 0) effort_seen = 1;
                if (mode == MODE_HOMING) begin
                    e = home[j] - held[j];
                    t = pd_effort(j, e, p);
                    if (t > TORQUE_LIMIT) t = TORQUE_LIMIT;
                    if (t < -TORQUE_LIMIT) t = -TORQUE_LIMIT;
                    r.torque = 16'(t);
                    if ((e < 0 ? -e : e) > int'(tol)) unhomed = 1;
                end else if (mode == MODE_EXTERNAL) begin
                    r.torque = w.eff;
                end else begin
                    t = pd_effort(j, held[j] - cur[j], p);
                    if (t > 32767) t = 32767;
                    if (t < -32768) t = -32768;
                    r.torque = 16'(t);
                end
                if (w.last) begin
                    if (mode == MODE_HOMING) begin
                        if (!unhomed) mode = MODE_HOLDING;
                    end else if (mode == MODE_EXTERNAL) begin
                        if (!effort_seen) mode = MODE_HOLDING;
                    end else begin
                        if (effort_seen) mode = MODE_EXTERNAL;
                    end
                    effort_seen = 0;
                    unhomed = 0;
                end
            end else if (w.cmd == CMD_LOAD) begin
                home[j] = int'(w.pos);
            end
            if (mode != old_mode) mode_changes++;
            r.mode = mode;
            pending_q.push_back(r);
        endfunction

        task report(string s);
            $display("MISMATCH at %0t: %s", $realtime, s);
            errors++;
        endtask

        task check(t_out_word r);
            t_out_word x;
            if (pending_q.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            x = pending_q.pop_front();
            checked++;
            if (r.torque !== x.torque)
                report($sformatf("torque %0d, expected %0d", r.torque, x.torque));
            if (r.rpos !== x.rpos)
                report($sformatf("position %0d, expected %0d", r.rpos, x.rpos));
            if (r.rvel !== x.rvel)
                report($sformatf("velocity %0d, expected %0d", r.rvel, x.rvel));
            if (r.mode !== x.mode)
                report($sformatf("mode %0d, expected %0d", r.mode, x.mode));
        endtask
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_AW-1:0]   i_cfg_idx;
    logic [CFG_DW-1:0]   i_cfg_data;

    mjpd_in_if  in_if ();
    mjpd_out_if out_if ();

    multi_joint_pd_homing_controller uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    pd_scoreboard sb;
    int send_pct = 0;
    int recv_pct = 0;
    int words_sent, frames_sent;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    // Receiver: check on an accepting edge, then choose the next ready level.
    always @(posedge i_clk) begin
        t_out_word r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            r.torque = out_if.torque;
            r.rpos = out_if.reported_position;
            r.rvel = out_if.reported_velocity;
            r.mode = out_if.mode;
            sb.check(r);
        end
        out_if.ready <= i_rst_n && ($urandom_range(99) >= recv_pct);
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_pct) begin
            in_if.valid <= 0;
            @(posedge i_clk);
        end
        in_if.valid <= 1;
        in_if.cmd <= w.cmd;
        in_if.joint <= w.joint;
        in_if.measured_position <= w.pos;
        in_if.measured_velocity <= w.vel;
        in_if.effort <= w.eff;
        in_if.period_us <= w.per;
        in_if.last_joint <= w.last;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_word(w);
        words_sent++;
    endtask

    // Stop sending until every expected word is back, then let the block settle.
    task automatic drain();
        in_if.valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] d);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.set_reg(idx, d);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_gains(int unsigned kp, int unsigned kd, int unsigned tol);
        write_reg(REG_PROP_GAIN, 16'(kp));
        write_reg(REG_DERIV_GAIN, 16'(kd));
        write_reg(REG_HOME_TOL, 16'(tol));
    endtask

    function automatic t_in_word make_word(logic [1:0] c, int j, int p, int v, int e,
                                           int unsigned per, bit last);
        t_in_word w;
        w.cmd = c;
        w.joint = 4'(j);
        w.pos = 16'(p);
        w.vel = 16'(v);
        w.eff = 16'(e);
        w.per = 16'(per);
        w.last = last;
        return w;
    endfunction

    function automatic int unsigned pick_period();
        case ($urandom_range(7))
            0: return 0;
            1: return $urandom_range(65535);
            2: return $urandom_range(1, 20);
            default: return $urandom_range(500, 20000);
        endcase
    endfunction

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_word(make_word(2'($urandom_range(3)), $urandom_range(15),
                                       $urandom, $urandom, $urandom, $urandom,
                                       1'($urandom_range(1))));
    endtask

    // A well-formed frame: optional home loads, a sample per joint, a tick per joint up to a random cut.
    task automatic send_frame();
        bit near, zero_eff, cut;
        int stop_at, off, span, p, j;
        near = ($urandom_range(1) == 1);
        zero_eff = ($urandom_range(1) == 1);
        cut = ($urandom_range(9) == 0);
        stop_at = cut ? $urandom_range(15) : JOINTS - 1;
        if ($urandom_range(3) == 0) begin
            for (j = 0; j < JOINTS; j++)
                if ($urandom_range(1) == 1)
                    send_word(make_word(CMD_LOAD, j,
                                        ($urandom_range(7) == 0) ? int'($urandom)
                                                                 : $urandom_range(4000) - 2000,
                                        $urandom, $urandom, pick_period(),
                                        1'($urandom_range(1))));
        end
        for (j = 0; j < JOINTS; j++) begin
            span = (sb.tol > 2000) ? 2000 : sb.tol;
            off = (span == 0) ? 0 : $urandom_range(2 * span) - span;
            p = near ? sb.home[j] + off : int'($urandom);
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            send_word(make_word(CMD_SAMPLE, j, p, $urandom, $urandom, pick_period(), 0));
        end
        for (j = 0; j <= stop_at; j++)
            send_word(make_word(CMD_CONTROL, j, $urandom, $urandom,
                                zero_eff ? 0 : (($urandom_range(3) == 0) ? 0 : int'($urandom)),
                                pick_period(), j == stop_at));
        frames_sent++;
    endtask

    task automatic run_random(int n);
        int target;
        target = words_sent + n;
        while (words_sent < target) begin
            if ($urandom_range(9) == 0) send_noise();
            else send_frame();
        end
    endtask

    task automatic run_directed();
        send_word(make_word(CMD_LOAD, 0, 32767, 0, 0, 0, 0));
        send_word(make_word(CMD_LOAD, 15, -32768, 0, 0, 65535, 1));
        send_word(make_word(CMD_SAMPLE, 0, -32768, 32767, 0, 0, 0));
        send_word(make_word(CMD_SAMPLE, 15, 32767, -32768, 0, 1, 1));
        send_word(make_word(CMD_CONTROL, 0, 0, 0, 32767, 0, 0));
        send_word(make_word(CMD_CONTROL, 15, 0, 0, -32768, 65535, 1));
        send_word(make_word(CMD_RESERVED, 7, 32767, -1, -1, 65535, 1));
        send_word(make_word(CMD_LOAD, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_LOAD, 15, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_SAMPLE, 0, 0, 5, 0, 0, 0));
        send_word(make_word(CMD_SAMPLE, 15, 0, -5, 0, 0, 0));
        // A clean homing frame moves to holding.
        send_word(make_word(CMD_CONTROL, 3, 0, 0, 0, 10000, 1));
        send_word(make_word(CMD_SAMPLE, 4, 32767, 32767, 0, 0, 0));
        send_word(make_word(CMD_CONTROL, 4, 0, 0, 0, 1, 0));
        // Nonzero effort moves holding to external control.
        send_word(make_word(CMD_CONTROL, 5, 0, 0, -1, 0, 1));
        send_word(make_word(CMD_SAMPLE, 6, -32768, -32768, 0, 0, 0));
        send_word(make_word(CMD_CONTROL, 6, 0, 0, 12345, 0, 0));
        send_word(make_word(CMD_SAMPLE, 6, 100, 1, 0, 0, 1));
        send_word(make_word(CMD_CONTROL, 6, 0, 0, 0, 0, 1));
        send_word(make_word(CMD_CONTROL, 4, 0, 0, 0, 65535, 1));
    endtask

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_if.valid = 0;
        in_if.cmd = '0;
        in_if.joint = '0;
        in_if.measured_position = '0;
        in_if.measured_velocity = '0;
        in_if.effort = '0;
        in_if.period_us = '0;
        in_if.last_joint = 0;
        sb = new();
        words_sent = 0;
        frames_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        send_pct = 24;
        recv_pct = 77;
        run_directed();
        drain();
        set_gains(300, 2, 200);
        write_reg(REG_UNUSED, 16'hFFFF);
        run_random(430);
        drain();

        send_pct = 77;
        recv_pct = 24;
        set_gains(65535, 65535, 0);
        run_random(430);
        drain();

        send_pct = 0;
        recv_pct = 0;
        set_gains(0, 0, 32767);
        run_random(250);
        drain();
        set_gains(1000, 5, 100);
        run_random(200);
        drain();

        $display("sent %0d words in %0d frames, checked %0d results, %0d mode changes",
                 words_sent, frames_sent, sb.checked, sb.mode_changes);
        $display("gains swept from zero to full scale, tolerance from zero to maximum");
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches, %0d words outstanding", sb.errors, sb.pending_q.size());
            $display("status: fail");
        end
        $finish;
    end
endmodule
